// ===== rtl/core/rect_iou_pkg.sv =====
package rect_iou_pkg;

  localparam int COORD_BITS      = 12;
  localparam int SCORE_FRAC_BITS = 16;
  localparam int SCORE_BITS      = SCORE_FRAC_BITS + 1;
  localparam int MAX_CANDIDATES  = 256;
  localparam int SLOT_BITS       = 8;
  localparam int SLOT_MAX        = (1 << SLOT_BITS) - 1;
  localparam int POS_LIMIT       = (MAX_CANDIDATES - 1 > SLOT_MAX) ? SLOT_MAX
                                                                   : MAX_CANDIDATES - 1;
  localparam int AREA_BITS       = 2 * COORD_BITS;
  localparam int UNION_BITS      = AREA_BITS + 1;
  localparam int REM_BITS        = UNION_BITS + 1;
  localparam int DIV_STEPS       = SCORE_BITS;
  localparam int CNT_BITS        = $clog2(DIV_STEPS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [AREA_BITS-1:0]  area_t;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_INTER = 2'd0;
  localparam mul_sel_t MUL_REF   = 2'd1;
  localparam mul_sel_t MUL_CAND  = 2'd2;

  typedef struct packed {
    coord_t ref_left;
    coord_t ref_top;
    coord_t ref_right;
    coord_t ref_bottom;
    coord_t cand_left;
    coord_t cand_top;
    coord_t cand_right;
    coord_t cand_bottom;
    logic   last_pair;
  } pair_t;

  typedef struct packed {
    score_t pair_score;
    logic   overlaps;
    score_t best_score;
    slot_t  best_position;
    logic   has_match;
    logic   set_done;
  } result_t;

  typedef struct packed {
    logic     load;
    logic     edges;
    logic     spans;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     union_en;
    logic     div_step;
    logic     update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/rect_iou_ctrl.sv =====
module rect_iou_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pair_valid,
  output logic                     idle,
  input  rect_iou_pkg::ctrl_stat_t stat,
  output rect_iou_pkg::ctrl_cmd_t  cmd
);
  import rect_iou_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EDGE   = 4'd1;
  localparam logic [3:0] ST_SPAN   = 4'd2;
  localparam logic [3:0] ST_MUL_I  = 4'd3;
  localparam logic [3:0] ST_MUL_R  = 4'd4;
  localparam logic [3:0] ST_MUL_C  = 4'd5;
  localparam logic [3:0] ST_UNION  = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_UPDATE = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] cnt_next;

  assign idle = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = MUL_INTER;
    unique case (state)
      ST_IDLE: begin
        if (pair_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.edges  = 1'b1;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.spans  = 1'b1;
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INTER;
        state_next  = stat.hit ? ST_MUL_R : ST_UPDATE;
      end
      ST_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_REF;
        state_next  = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CAND;
        state_next  = ST_UNION;
      end
      ST_UNION: begin
        cmd.union_en = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_STEPS - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/rect_iou_dp.sv =====
module rect_iou_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  rect_iou_pkg::pair_t      pair,
  input  rect_iou_pkg::ctrl_cmd_t  cmd,
  output rect_iou_pkg::ctrl_stat_t stat,
  output logic                     result_valid,
  input  logic                     result_ready,
  output rect_iou_pkg::result_t    result
);
  import rect_iou_pkg::*;

  pair_t                 pair_q;
  coord_t                ix0, iy0, ix1, iy1;
  coord_t                rw, rh, cw, ch;
  coord_t                iw, ih;
  logic                  hit;
  coord_t                mul_a, mul_b;
  area_t                 area_i, area_r, area_c;
  logic [UNION_BITS-1:0] uni;
  logic [REM_BITS-1:0]   rem;
  logic [REM_BITS-1:0]   rem_trial;
  logic [REM_BITS-1:0]   rem_kept;
  logic                  rem_ge;
  score_t                quo;
  score_t                best_value, best_value_next;
  slot_t                 best_slot, best_slot_next;
  logic                  match_seen, match_seen_next;
  slot_t                 position_count;
  score_t                score;
  result_t               result_q;
  logic                  out_valid;

  assign stat.hit      = hit;
  assign stat.out_busy = out_valid && !result_ready;
  assign result_valid  = out_valid;
  assign result        = result_q;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_INTER: begin
        mul_a = iw;
        mul_b = ih;
      end
      MUL_REF: begin
        mul_a = rw;
        mul_b = rh;
      end
      default: begin
        mul_a = cw;
        mul_b = ch;
      end
    endcase
  end

  assign rem_ge    = rem >= REM_BITS'(uni);
  assign rem_trial = rem - REM_BITS'(uni);
  assign rem_kept  = rem_ge ? rem_trial : rem;

  always_comb begin
    score           = hit ? quo : '0;
    best_value_next = best_value;
    best_slot_next  = best_slot;
    match_seen_next = match_seen;
    if (hit && (quo > best_value)) begin
      best_value_next = quo;
      best_slot_next  = position_count;
      match_seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pair_q <= pair;
    end
    if (cmd.edges) begin
      ix0 <= (pair_q.ref_left > pair_q.cand_left) ? pair_q.ref_left : pair_q.cand_left;
      iy0 <= (pair_q.ref_top > pair_q.cand_top) ? pair_q.ref_top : pair_q.cand_top;
      ix1 <= (pair_q.ref_right < pair_q.cand_right) ? pair_q.ref_right : pair_q.cand_right;
      iy1 <= (pair_q.ref_bottom < pair_q.cand_bottom) ? pair_q.ref_bottom
                                                       : pair_q.cand_bottom;
      rw  <= pair_q.ref_right - pair_q.ref_left;
      rh  <= pair_q.ref_bottom - pair_q.ref_top;
      cw  <= pair_q.cand_right - pair_q.cand_left;
      ch  <= pair_q.cand_bottom - pair_q.cand_top;
    end
    if (cmd.spans) begin
      iw  <= ix1 - ix0;
      ih  <= iy1 - iy0;
      hit <= (ix0 < ix1) && (iy0 < iy1);
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_INTER: area_i <= mul_a * mul_b;
        MUL_REF:   area_r <= mul_a * mul_b;
        default:   area_c <= mul_a * mul_b;
      endcase
    end
    if (cmd.union_en) begin
      uni <= UNION_BITS'(area_r) + UNION_BITS'(area_c) - UNION_BITS'(area_i);
      rem <= REM_BITS'(area_i);
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= {rem_kept[REM_BITS-2:0], 1'b0};
      quo <= {quo[SCORE_BITS-2:0], rem_ge};
    end
    if (cmd.update) begin
      result_q.pair_score    <= score;
      result_q.overlaps      <= hit;
      result_q.best_score    <= best_value_next;
      result_q.best_position <= best_slot_next;
      result_q.has_match     <= match_seen_next;
      result_q.set_done      <= pair_q.last_pair;
    end
  end

  // running best of the set, position counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      best_value     <= '0;
      best_slot      <= '0;
      match_seen     <= 1'b0;
      position_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.update) begin
        out_valid <= 1'b1;
        if (pair_q.last_pair) begin
          best_value     <= '0;
          best_slot      <= '0;
          match_seen     <= 1'b0;
          position_count <= '0;
        end else begin
          best_value <= best_value_next;
          best_slot  <= best_slot_next;
          match_seen <= match_seen_next;
          if (position_count < SLOT_BITS'(POS_LIMIT)) begin
            position_count <= position_count + 1'b1;
          end
        end
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/rect_iou_best_match.sv =====
// channel  | direction | handshake                   | payload
// pair     | in        | pair_valid / pair_ready     | rect_iou_pkg::pair_t
// result   | out       | result_valid / result_ready | rect_iou_pkg::result_t
//
// One transaction at a time. A miss takes one pass of the shared 12x12 multiplier;
// an overlap takes three passes of it and then a 17-step restoring divider.
// The result sits in an output register; the next pair is taken while it waits.
// Synchronous reset clears the running best, position counter and result valid.
// A stalled result holds the final update step until the register frees up.
module rect_iou_best_match (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pair_valid,
  output logic                  pair_ready,
  input  rect_iou_pkg::pair_t   pair,
  output logic                  result_valid,
  input  logic                  result_ready,
  output rect_iou_pkg::result_t result
);
  import rect_iou_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  rect_iou_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .idle       (pair_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rect_iou_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .pair         (pair),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.pair_score <= SCORE_BITS'(1 << SCORE_FRAC_BITS))
    else $error("pair score above one");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.overlaps) |-> result.pair_score == '0)
    else $error("nonzero score without overlap");

  a_no_match_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.has_match) |->
      (result.best_score == '0 && result.best_position == '0))
    else $error("best set without a match");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (pair_valid && pair_ready) |=> !pair_ready)
    else $error("second transaction taken while busy");

endmodule
